### src/rne_pkg.sv
`default_nettype none
package rne_pkg;

  // highest convertible value plus one
  localparam int VALUE_LIMIT = 5000;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_V = 8'h56;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_L = 8'h4c;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_M = 8'h4d;

  // decade positions, most significant first
  localparam logic [1:0] DEC_THOU = 2'd0;
  localparam logic [1:0] DEC_HUND = 2'd1;
  localparam logic [1:0] DEC_TENS = 2'd2;
  localparam logic [1:0] DEC_ONES = 2'd3;

  // symbol within a decade: one, five, next decade's one
  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic       oor;
    logic       lower;
    logic [2:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } desc_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_THOU,
    FS_HUND,
    FS_TENS,
    FS_PUSH
  } front_state_t;

  typedef enum logic {
    BS_IDLE,
    BS_EMIT
  } back_state_t;

  // number of letters a decimal digit takes
  function automatic logic [2:0] pat_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // symbol at position p of the subtractive pattern for digit d
  function automatic sym_t pat_sym(input logic [3:0] d, input logic [1:0] p);
    sym_t s;
    case (d)
      4'd4:    s = (p == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd5,
      4'd6,
      4'd7,
      4'd8:    s = (p == 2'd0) ? SYM_FIVE : SYM_ONE;
      4'd9:    s = (p == 2'd0) ? SYM_ONE : SYM_TEN;
      default: s = SYM_ONE;
    endcase
    return s;
  endfunction

  // uppercase letter for a symbol in a decade
  function automatic logic [7:0] dec_letter(input logic [1:0] dec, input sym_t s);
    logic [7:0] ch;
    case (dec)
      DEC_THOU: ch = CHAR_M;
      DEC_HUND: ch = (s == SYM_ONE) ? CHAR_C : ((s == SYM_FIVE) ? CHAR_D : CHAR_M);
      DEC_TENS: ch = (s == SYM_ONE) ? CHAR_X : ((s == SYM_FIVE) ? CHAR_L : CHAR_C);
      DEC_ONES: ch = (s == SYM_ONE) ? CHAR_I : ((s == SYM_FIVE) ? CHAR_V : CHAR_X);
      default:  ch = CHAR_M;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### src/rne_front.sv
`default_nettype none
module rne_front
  import rne_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_lower_case,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output desc_t                   push_data
);

  // largest k in 0..9 with k*unit <= v
  function automatic logic [3:0] dig_of(input logic [12:0] v, input logic [12:0] unit);
    logic [3:0]  d;
    logic [16:0] thr;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      thr = 17'(k) * {4'd0, unit};
      if ({4'd0, v} >= thr) d = 4'(k);
    end
    return d;
  endfunction

  function automatic logic [12:0] rem_of(input logic [12:0] v, input logic [3:0] d,
                                         input logic [12:0] unit);
    logic [16:0] sub;
    sub = {13'd0, d} * {4'd0, unit};
    return v - sub[12:0];
  endfunction

  front_state_t state_r, state_nxt;
  desc_t        desc_r, desc_nxt;
  logic [12:0]  rem_r, rem_nxt;
  logic [3:0]   dig;
  logic         in_range;

  assign in_range = (in_value > 32'sd0) && (in_value < 32'(VALUE_LIMIT));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: if (in_valid) state_nxt = in_range ? FS_THOU : FS_PUSH;
      FS_THOU: state_nxt = FS_HUND;
      FS_HUND: state_nxt = FS_TENS;
      FS_TENS: state_nxt = FS_PUSH;
      FS_PUSH: if (push_ready) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == FS_IDLE);
    push_valid = (state_r == FS_PUSH);
    push_data  = desc_r;
  end

  always_comb begin
    desc_nxt = desc_r;
    rem_nxt  = rem_r;
    dig      = 4'd0;
    case (state_r)
      FS_IDLE: begin
        desc_nxt       = '0;
        desc_nxt.oor   = !in_range;
        desc_nxt.lower = in_lower_case;
        rem_nxt        = in_value[12:0];
      end
      FS_THOU: begin
        dig           = dig_of(rem_r, 13'd1000);
        desc_nxt.thou = dig[2:0];
        rem_nxt       = rem_of(rem_r, dig, 13'd1000);
      end
      FS_HUND: begin
        dig           = dig_of(rem_r, 13'd100);
        desc_nxt.hund = dig;
        rem_nxt       = rem_of(rem_r, dig, 13'd100);
      end
      FS_TENS: begin
        dig           = dig_of(rem_r, 13'd10);
        desc_nxt.tens = dig;
        rem_nxt       = rem_of(rem_r, dig, 13'd10);
        desc_nxt.ones = rem_nxt[3:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r != FS_PUSH) begin
      desc_r <= desc_nxt;
      rem_r  <= rem_nxt;
    end
  end

  a_push_digits: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_data.oor |->
      push_data.hund <= 4'd9 && push_data.tens <= 4'd9 && push_data.ones <= 4'd9)
    else $error("digit above nine handed to back end");

  a_range_skips: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_range |=> state_r == FS_PUSH && desc_r.oor)
    else $error("out-of-range item not flagged");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_data.oor |->
      (push_data.thou != 3'd0 || push_data.hund != 4'd0 ||
       push_data.tens != 4'd0 || push_data.ones != 4'd0))
    else $error("in-range item with no digits");

endmodule
`default_nettype wire

### src/rne_queue.sv
`default_nettype none
module rne_queue
  import rne_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire desc_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output desc_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with fill count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

### src/rne_back.sv
`default_nettype none
module rne_back
  import rne_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire desc_t pop_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_letter,
  output logic       out_last,
  output logic       out_out_of_range
);

  back_state_t state_r, state_nxt;
  desc_t       desc_r;
  logic [1:0]  dec_r, dec_nxt;
  logic [1:0]  pat_r, pat_nxt;
  logic        out_valid_r;
  logic [7:0]  letter_r;
  logic        last_r;
  logic        oor_r;

  logic [2:0]  lens [4];
  logic [3:0]  cur_digit;
  logic        at_end;
  logic        has_next;
  logic [1:0]  next_dec;
  logic [1:0]  first_dec;
  logic        emit;
  logic        char_last;
  logic [7:0]  char_val;
  sym_t        sym;

  // first decade with any letters in a freshly popped item
  always_comb begin
    first_dec = DEC_ONES;
    if (pop_data.tens != 4'd0) first_dec = DEC_TENS;
    if (pop_data.hund != 4'd0) first_dec = DEC_HUND;
    if (pop_data.thou != 3'd0) first_dec = DEC_THOU;
  end

  always_comb begin
    lens[0] = desc_r.thou;
    lens[1] = pat_len(desc_r.hund);
    lens[2] = pat_len(desc_r.tens);
    lens[3] = pat_len(desc_r.ones);
    case (dec_r)
      DEC_HUND: cur_digit = desc_r.hund;
      DEC_TENS: cur_digit = desc_r.tens;
      DEC_ONES: cur_digit = desc_r.ones;
      default:  cur_digit = 4'd0;
    endcase
    at_end   = ({1'b0, pat_r} + 3'd1 == lens[dec_r]);
    has_next = 1'b0;
    next_dec = dec_r;
    for (int i = 3; i >= 0; i--) begin
      if (2'(i) > dec_r && lens[i] != 3'd0) begin
        has_next = 1'b1;
        next_dec = 2'(i);
      end
    end
  end

  // character for the current position
  always_comb begin
    sym       = (dec_r == DEC_THOU) ? SYM_ONE : pat_sym(cur_digit, pat_r);
    char_val  = dec_letter(dec_r, sym);
    if (desc_r.lower) char_val = char_val | CASE_BIT;
    char_last = at_end && !has_next;
    if (desc_r.oor) begin
      char_val  = 8'd0;
      char_last = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: if (pop_valid) state_nxt = BS_EMIT;
      BS_EMIT: if (emit && char_last) state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state_r == BS_IDLE);
    emit      = (state_r == BS_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    dec_nxt = dec_r;
    pat_nxt = pat_r;
    if (pop_valid && pop_ready) begin
      dec_nxt = first_dec;
      pat_nxt = 2'd0;
    end else if (emit) begin
      if (at_end) begin
        dec_nxt = next_dec;
        pat_nxt = 2'd0;
      end else begin
        pat_nxt = pat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
    pat_r <= pat_nxt;
    if (pop_valid && pop_ready) desc_r <= pop_data;
    if (emit) begin
      letter_r <= char_val;
      last_r   <= char_last;
      oor_r    <= desc_r.oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_letter       = letter_r;
  assign out_last         = last_r;
  assign out_out_of_range = oor_r;

  a_oor_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_last && out_letter == 8'd0)
    else $error("out-of-range result not a single zero character");

  a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_letter != 8'd0)
    else $error("in-range result carries no letter");

  a_emit_stays: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_EMIT && !(emit && char_last) |=> state_r == BS_EMIT)
    else $error("back end left a numeral before its last character");

endmodule
`default_nettype wire

### src/roman_numeral_encoder.sv
`default_nettype none
// Roman numeral encoder: each input transfer carries a signed 32-bit value and a
// case flag; the block answers with the numeral as a run of ASCII characters,
// one per output transfer, out_last high on the final one. Values 1 to 4999 are
// converted (4000 and up as MMMM); anything else gives a single transfer with
// letter 0, out_last and out_out_of_range high. The front end handles an
// in-range item in steps (range check, then split off thousands, hundreds and
// tens in turn) and then hands it to a small queue; an out-of-range item skips
// the split. The back end loads an item and then emits its characters one at
// a time, stalling while the output side holds off; a numeral has 1 to 16
// characters. With no stalls the sustained rate per item is set by the slower
// half, so short numerals of up to three characters are front-bound and longer
// ones back-bound. The queue lets the front end split the next value while the
// back end is still spelling the previous one.
module roman_numeral_encoder
  import rne_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_lower_case,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_letter,
  output logic                    out_last,
  output logic                    out_out_of_range
);

  // front to queue
  logic  fq_valid;
  logic  fq_ready;
  desc_t fq_data;
  // queue to back
  logic  qb_valid;
  logic  qb_ready;
  desc_t qb_data;

  // range check and decimal split
  rne_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_lower_case (in_lower_case),
    .push_valid    (fq_valid),
    .push_ready    (fq_ready),
    .push_data     (fq_data)
  );

  // decouples the two halves
  rne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // letter sequencer with registered output
  rne_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (qb_valid),
    .pop_ready        (qb_ready),
    .pop_data         (qb_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter       (out_letter),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule
`default_nettype wire

### verif/roman_numeral_encoder_tb.sv
`timescale 1ns / 100ps
module roman_numeral_encoder_tb;
  import rne_pkg::*;

  // cycles to let the pipeline settle once nothing is pending
  localparam int DRAIN_CYCLES = 40;

  // one expected character transfer
  typedef struct packed {
    logic [7:0] letter;
    logic       last;
    logic       oor;
  } glyph_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value = '0;
  logic               in_lower_case = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_letter;
  logic               out_last;
  logic               out_out_of_range;

  // characters still owed by the block, oldest first
  glyph_t pending_glyphs[$];
  glyph_t next_glyph;
  int     mismatches = 0;

  // when set, that side starts no new random idles
  logic   steady_in = 1'b0;
  logic   steady_out = 1'b0;
  int     hold_left = 0;

  roman_numeral_encoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_lower_case    (in_lower_case),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_letter       (out_letter),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 24);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void push_glyph(input logic [7:0] ch, input logic lower);
    glyph_t g;
    g.letter = lower ? (ch | CASE_BIT) : ch;
    g.last   = 1'b0;
    g.oor    = 1'b0;
    pending_glyphs.push_back(g);
  endfunction

  // expected spelling of one value: thousands as repeated M, then each decade
  // through its subtractive pattern; anything outside 1..4999 is one error transfer
  function automatic void spell_numeral(input logic signed [31:0] value, input logic lower);
    int         v;
    int         d;
    int         k;
    int         j;
    glyph_t     g;
    logic [7:0] one_ch  [0:2];
    logic [7:0] five_ch [0:2];
    logic [7:0] ten_ch  [0:2];
    int         digit   [0:2];
    if (value < 1 || value >= VALUE_LIMIT) begin
      g.letter = 8'h00;
      g.last   = 1'b1;
      g.oor    = 1'b1;
      pending_glyphs.push_back(g);
      return;
    end
    v = value;
    one_ch[0] = CHAR_C;  five_ch[0] = CHAR_D;  ten_ch[0] = CHAR_M;
    one_ch[1] = CHAR_X;  five_ch[1] = CHAR_L;  ten_ch[1] = CHAR_C;
    one_ch[2] = CHAR_I;  five_ch[2] = CHAR_V;  ten_ch[2] = CHAR_X;
    digit[0] = (v / 100) % 10;
    digit[1] = (v / 10) % 10;
    digit[2] = v % 10;
    for (j = 0; j < v / 1000; j++) begin
      push_glyph(CHAR_M, lower);
    end
    for (k = 0; k < 3; k++) begin
      d = digit[k];
      case (d)
        4: begin
          push_glyph(one_ch[k], lower);
          push_glyph(five_ch[k], lower);
        end
        9: begin
          push_glyph(one_ch[k], lower);
          push_glyph(ten_ch[k], lower);
        end
        default: begin
          if (d >= 5) begin
            push_glyph(five_ch[k], lower);
          end
          for (j = 0; j < d % 5; j++) begin
            push_glyph(one_ch[k], lower);
          end
        end
      endcase
    end
    pending_glyphs[pending_glyphs.size() - 1].last = 1'b1;
  endfunction

  // called at a falling edge; after a random idle gap unless steady_in, drives in_valid high with the value
  task automatic send_value(input logic signed [31:0] value, input logic lower);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= value;
    in_lower_case <= lower;
    // hold until the transfer happens at a rising edge
    do begin
      @(posedge clk);
    end while (!in_ready);
    spell_numeral(in_value, in_lower_case);
    @(negedge clk);
  endtask

  // stop sending and wait for every owed character, plus settle time
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // range edges, the subtractive digit patterns, the 16-character worst case, both cases
  task automatic test_directed();
    send_value(32'sd1, 1'b0);
    send_value(32'sd4, 1'b1);
    send_value(32'sd5, 1'b0);
    send_value(32'sd9, 1'b1);
    send_value(32'sd14, 1'b0);
    send_value(32'sd40, 1'b1);
    send_value(32'sd90, 1'b0);
    send_value(32'sd400, 1'b1);
    send_value(32'sd900, 1'b0);
    send_value(32'sd3999, 1'b1);
    send_value(32'sd4000, 1'b0);
    send_value(32'sd4888, 1'b0);
    send_value(32'sd4888, 1'b1);
    send_value(32'sd4999, 1'b1);
    send_value(32'sd2678, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b1);
    send_value(32'sd5000, 1'b0);
    send_value(32'sh7fffffff, 1'b1);
    send_value(32'sh80000000, 1'b0);
    wait_idle();
  endtask

  // sender holds off until the block has fully drained, several times
  task automatic test_drain_pause();
    int n;
    for (n = 0; n < 4; n++) begin
      send_value($urandom_range(1, 4999), $urandom_range(0, 1));
      send_value($urandom_range(1, 4999), $urandom_range(0, 1));
      wait_idle();
    end
  endtask

  task automatic test_random_in_range();
    int n;
    for (n = 0; n < 300; n++) begin
      send_value($urandom_range(1, 4999), $urandom_range(0, 1));
    end
  endtask

  // out-of-range values mixed in: any 32-bit word, near zero, near the limit
  task automatic test_random_mixed();
    int                 n;
    logic signed [31:0] v;
    for (n = 0; n < 90; n++) begin
      case ($urandom_range(0, 4))
        0:       v = $urandom;
        1:       v = $urandom_range(4990, 5010);
        2:       v = $signed($urandom_range(0, 20)) - 10;
        3:       v = -$signed($urandom_range(1, 100000));
        default: v = $urandom_range(1, 4999);
      endcase
      send_value(v, $urandom_range(0, 1));
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    int n;
    steady_in  = 1'b1;
    steady_out = 1'b1;
    for (n = 0; n < 40; n++) begin
      send_value(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 4999),
                 $urandom_range(0, 1));
    end
    wait_idle();
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  // receiver stalls: random holds of random length, none started while steady_out
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= 1'b1;
      if (!steady_out && $urandom_range(0, 3) == 0) begin
        hold_left = pick_gap();
      end
    end
  end

  // each character transfer against the oldest owed character
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer letter=%02h last=%b oor=%b",
                                  out_letter, out_last, out_out_of_range));
      end else begin
        next_glyph = pending_glyphs.pop_front();
        if (out_letter !== next_glyph.letter) begin
          report_mismatch($sformatf("letter %02h, wanted %02h", out_letter,
                                    next_glyph.letter));
        end
        if (out_last !== next_glyph.last) begin
          report_mismatch($sformatf("last %b, wanted %b", out_last, next_glyph.last));
        end
        if (out_out_of_range !== next_glyph.oor) begin
          report_mismatch($sformatf("out_of_range %b, wanted %b", out_out_of_range,
                                    next_glyph.oor));
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_drain_pause();
    test_random_in_range();
    test_back_to_back();
    test_random_mixed();
    // stimulus done; wait out everything still owed
    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
